[sv/eipc_pkg.sv]
// ----------------------------------------------------------------------------
// eipc_pkg: shared types and constants
// Item, result and configuration layouts, opcode and sense-mode codes for the
// external and pin-change interrupt controller.
// ----------------------------------------------------------------------------
package eipc_pkg;

  // Pin and bank counts
  localparam int EXT_PINS      = 2;
  localparam int PC_BANKS      = 3;
  localparam int PC_PINS       = 24;
  localparam int PINS_PER_BANK = 8;
  localparam int BANK_SHIFT    = $clog2(PINS_PER_BANK);

  // Field widths
  localparam int IDX_W   = 5;
  localparam int WV_W    = 8;
  localparam int SENSE_W = 2 * EXT_PINS;
  localparam int BANK_W  = IDX_W - BANK_SHIFT;

  // Event opcodes
  typedef enum logic [1:0] {
    OP_LEVEL  = 2'd0,
    OP_FLAG_WR = 2'd1,
    OP_ACK    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Pin groups
  typedef enum logic {
    KIND_EXT = 1'b0,
    KIND_PC  = 1'b1
  } kind_t;

  // External pin sense modes
  typedef enum logic [1:0] {
    SENSE_LOW    = 2'd0,
    SENSE_TOGGLE = 2'd1,
    SENSE_FALL   = 2'd2,
    SENSE_RISE   = 2'd3
  } sense_t;

  // Register indexes on the config port
  typedef enum logic [1:0] {
    REG_SENSE  = 2'd0,
    REG_EXT_EN = 2'd1,
    REG_PC_EN  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SENSE_W-1:0]  sense_control;
    logic [EXT_PINS-1:0] ext_enable_mask;
    logic [PC_PINS-1:0]  pc_enable_mask;
  } cfg_t;

  typedef struct packed {
    op_t              opcode;
    kind_t            pin_kind;
    logic [IDX_W-1:0] pin_index;
    logic             new_level;
    logic [WV_W-1:0]  write_value;
  } item_t;

  typedef struct packed {
    logic [EXT_PINS-1:0] ext_flags;
    logic [PC_BANKS-1:0] pc_flags;
    logic [EXT_PINS-1:0] ext_pending;
    logic [PC_BANKS-1:0] pc_pending;
    logic                fired;
    logic [1:0]          edge_code;
  } result_t;

endpackage

[sv/eipc_cfg.sv]
// ----------------------------------------------------------------------------
// eipc_cfg: configuration registers
// Bus-side register file for sense modes and enable masks.
// ----------------------------------------------------------------------------
module eipc_cfg import eipc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic     wr_en;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SENSE:  cfg.sense_control   <= pwdata[SENSE_W-1:0];
        REG_EXT_EN: cfg.ext_enable_mask <= pwdata[EXT_PINS-1:0];
        REG_PC_EN:  cfg.pc_enable_mask  <= pwdata[PC_PINS-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_SENSE:  prdata = 32'(cfg.sense_control);
      REG_EXT_EN: prdata = 32'(cfg.ext_enable_mask);
      REG_PC_EN:  prdata = 32'(cfg.pc_enable_mask);
      default:    prdata = '0;
    endcase
  end

endmodule

[sv/eipc_core.sv]
// ----------------------------------------------------------------------------
// eipc_core: interrupt state and event logic
// Holds pin levels, flags and request lines; applies one event per enabled
// cycle and reports the resulting state.
// ----------------------------------------------------------------------------
module eipc_core import eipc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    enable,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam logic [EXT_PINS-1:0] EXT_ONE  = {{(EXT_PINS-1){1'b0}}, 1'b1};
  localparam logic [PC_BANKS-1:0] BANK_ONE = {{(PC_BANKS-1){1'b0}}, 1'b1};
  localparam logic [PC_PINS-1:0]  PIN_ONE  = {{(PC_PINS-1){1'b0}}, 1'b1};

  logic [EXT_PINS-1:0] ext_levels, ext_levels_next;
  logic [PC_PINS-1:0]  pc_levels, pc_levels_next;
  logic [EXT_PINS-1:0] ext_flag_bits, ext_flag_bits_next;
  logic [PC_BANKS-1:0] pc_flag_bits, pc_flag_bits_next;
  logic [EXT_PINS-1:0] ext_request, ext_request_next;
  logic [PC_BANKS-1:0] pc_request, pc_request_next;

  sense_t              sense_mode [EXT_PINS];
  logic [EXT_PINS-1:0] low_held;
  logic [EXT_PINS-1:0] ext_bit;
  logic [PC_PINS-1:0]  pc_bit;
  logic [PC_BANKS-1:0] bank_bit;
  logic [PC_BANKS-1:0] ack_bank_bit;
  logic                ext_ok, pc_ok, bank_ok;
  logic                ext_old, pc_old, trig;
  logic [EXT_PINS-1:0] ext_clr;
  logic [PC_BANKS-1:0] pc_clr;
  logic                fired;
  logic [1:0]          edge_code;

  // per-pin sense mode and held low-level condition
  always_comb begin
    for (int i = 0; i < EXT_PINS; i++) begin
      sense_mode[i] = sense_t'(cfg.sense_control[2*i +: 2]);
      low_held[i]   = (sense_mode[i] == SENSE_LOW) && !ext_levels[i] &&
                      cfg.ext_enable_mask[i];
    end
  end

  // pin / bank selection
  assign ext_ok       = item.pin_index < IDX_W'(EXT_PINS);
  assign pc_ok        = item.pin_index < IDX_W'(PC_PINS);
  assign bank_ok      = item.pin_index < IDX_W'(PC_BANKS);
  assign ext_bit      = ext_ok ? (EXT_ONE << item.pin_index) : '0;
  assign pc_bit       = pc_ok ? (PIN_ONE << item.pin_index) : '0;
  assign bank_bit     = BANK_ONE << item.pin_index[IDX_W-1 -: BANK_W];
  assign ack_bank_bit = bank_ok ? (BANK_ONE << item.pin_index) : '0;
  assign ext_old      = |(ext_levels & ext_bit);
  assign pc_old       = |(pc_levels & pc_bit);

  // external trigger by sense mode of the addressed pin
  always_comb begin
    trig = 1'b0;
    for (int i = 0; i < EXT_PINS; i++) begin
      if (ext_bit[i]) begin
        case (sense_mode[i])
          SENSE_LOW:    trig = !item.new_level;
          SENSE_TOGGLE: trig = item.new_level ^ ext_old;
          SENSE_FALL:   trig = !item.new_level && ext_old;
          SENSE_RISE:   trig = item.new_level && !ext_old;
          default:      trig = 1'b0;
        endcase
        trig = trig && cfg.ext_enable_mask[i];
      end
    end
  end

  // next state for the event
  always_comb begin
    ext_levels_next = ext_levels;
    pc_levels_next  = pc_levels;
    ext_clr         = '0;
    pc_clr          = '0;
    fired           = 1'b0;
    edge_code       = '0;
    ext_flag_bits_next = ext_flag_bits;
    ext_request_next   = ext_request;
    pc_flag_bits_next  = pc_flag_bits;
    pc_request_next    = pc_request;

    unique case (item.opcode)
      OP_LEVEL: begin
        if (item.pin_kind == KIND_EXT) begin
          if (ext_ok) begin
            if (trig) begin
              ext_flag_bits_next = ext_flag_bits | ext_bit;
              ext_request_next   = ext_request | ext_bit;
              fired              = 1'b1;
              edge_code          = {ext_old, item.new_level};
            end
            ext_levels_next = item.new_level ? (ext_levels | ext_bit)
                                             : (ext_levels & ~ext_bit);
          end
        end else if (pc_ok) begin
          if (|(cfg.pc_enable_mask & pc_bit) && (item.new_level ^ pc_old)) begin
            pc_flag_bits_next = pc_flag_bits | bank_bit;
            pc_request_next   = pc_request | bank_bit;
            fired             = 1'b1;
            edge_code         = {pc_old, item.new_level};
          end
          pc_levels_next = item.new_level ? (pc_levels | pc_bit)
                                          : (pc_levels & ~pc_bit);
        end
      end
      OP_FLAG_WR: begin
        if (item.pin_kind == KIND_EXT) ext_clr = item.write_value[EXT_PINS-1:0];
        else                           pc_clr  = item.write_value[PC_BANKS-1:0];
      end
      OP_ACK: begin
        if (item.pin_kind == KIND_EXT) ext_clr = ext_bit;
        else                           pc_clr  = ack_bank_bit;
      end
      default: ;
    endcase

    // clear, or for external pins keep set where a low level still holds
    if (|ext_clr) begin
      ext_flag_bits_next = (ext_flag_bits & ~ext_clr) | (ext_clr & low_held);
      ext_request_next   = (ext_request & ~ext_clr) | (ext_clr & low_held);
    end
    if (|pc_clr) begin
      pc_flag_bits_next = pc_flag_bits & ~pc_clr;
      pc_request_next   = pc_request & ~pc_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_levels    <= '0;
      pc_levels     <= '0;
      ext_flag_bits <= '0;
      pc_flag_bits  <= '0;
      ext_request   <= '0;
      pc_request    <= '0;
    end else if (enable) begin
      ext_levels    <= ext_levels_next;
      pc_levels     <= pc_levels_next;
      ext_flag_bits <= ext_flag_bits_next;
      pc_flag_bits  <= pc_flag_bits_next;
      ext_request   <= ext_request_next;
      pc_request    <= pc_request_next;
    end
  end

  // report state after the event
  always_comb begin
    result.ext_flags   = ext_flag_bits_next;
    result.pc_flags    = pc_flag_bits_next;
    result.ext_pending = ext_request_next;
    result.pc_pending  = pc_request_next;
    result.fired       = fired;
    result.edge_code   = edge_code;
  end

endmodule

[sv/external_and_pin_change_interrupt.sv]
// ----------------------------------------------------------------------------
// external_and_pin_change_interrupt: external and pin-change interrupt block
// Stream-in events, stream-out flag and request status.
// ----------------------------------------------------------------------------
// Each input word is one event (pin level change, write-one-to-clear flag
// write, or acknowledge) and yields exactly one output word with the flags,
// request lines and a fire indication. An event is registered on entry and its
// result in the output register; one event is taken every cycle, limited only by
// the output register draining through m_tready. The user must write configuration
// over the APB port only while the block is idle; the block does not enforce it.
module external_and_pin_change_interrupt import eipc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // pin_index[4:0], new_level[5], write_value[13:6]
  input  logic [2:0]  s_tuser,   // opcode[1:0], pin_kind[2]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // ext_flags[1:0], pc_flags[4:2], ext_pending[6:5],
                                 // pc_pending[9:7], fired[10], edge_code[12:11]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid;
  result_t core_res;
  result_t res_q;
  logic    advance;

  eipc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage handshake
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_q.opcode      <= op_t'(s_tuser[1:0]);
      item_q.pin_kind    <= kind_t'(s_tuser[2]);
      item_q.pin_index   <= s_tdata[4:0];
      item_q.new_level   <= s_tdata[5];
      item_q.write_value <= s_tdata[13:6];
    end
  end

  eipc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .enable (advance),
    .item   (item_q),
    .cfg    (cfg),
    .result (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= core_res;
    end
  end

  assign m_tdata = {3'b000, res_q.edge_code, res_q.fired, res_q.pc_pending,
                    res_q.ext_pending, res_q.pc_flags, res_q.ext_flags};

  // flags and request lines always move together
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res_q.ext_flags == res_q.ext_pending))
    else $error("external flag and request lines disagree");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res_q.pc_flags == res_q.pc_pending))
    else $error("pin-change flag and request lines disagree");

  // edge code only reported with a fire
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res_q.fired) |-> (res_q.edge_code == 2'b00))
    else $error("edge code set without fire");

  // full input stage behind a stalled output blocks the input
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while pipeline is full");

endmodule
